### rtl/core/iirl_pkg.sv
// ---------------------------------------------------------------------------
// iirl_pkg
// Shared types and constants for the indexed insert/remove list.
// ---------------------------------------------------------------------------
package iirl_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;

    localparam int LIST_CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W      = ((LIST_CNT_W > POS_W) ? LIST_CNT_W : POS_W) + 1;

    localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                  ins_en;
        logic                  rem_en;
        logic [CMP_W-1:0]      pos;
        logic [CMP_W-1:0]      count;
        logic [ELEM_WIDTH-1:0] value;
    } cell_cmd_t;

endpackage

### rtl/core/iirl_cell.sv
// ---------------------------------------------------------------------------
// iirl_cell
// One list slot: holds an element and loads the new value or a neighbor's.
// ---------------------------------------------------------------------------
module iirl_cell
    import iirl_pkg::*;
(
    input  logic                  aclk,
    input  cell_cmd_t             cmd,
    input  logic [CMP_W-1:0]      cell_index,
    input  logic [ELEM_WIDTH-1:0] left_data,
    input  logic [ELEM_WIDTH-1:0] right_data,
    output logic [ELEM_WIDTH-1:0] cell_data,
    output logic                  pos_hit
);

    logic [ELEM_WIDTH-1:0] cell_data_reg;
    logic [ELEM_WIDTH-1:0] cell_data_next;
    logic [CMP_W-1:0]      index_plus_one;

    assign index_plus_one = CMP_W'(cell_index + CMP_W'(1));
    assign pos_hit        = (cell_index == cmd.pos);

    always_comb begin
        cell_data_next = cell_data_reg;
        if (cmd.ins_en) begin
            if (pos_hit) begin
                cell_data_next = cmd.value;
            end else if ((cell_index > cmd.pos) && (cell_index <= cmd.count)) begin
                cell_data_next = left_data;
            end
        end else if (cmd.rem_en) begin
            if ((cell_index >= cmd.pos) && (index_plus_one < cmd.count)) begin
                cell_data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cell_data_reg <= cell_data_next;
    end

    assign cell_data = cell_data_reg;

endmodule

### rtl/core/indexed_insert_remove_list.sv
// ---------------------------------------------------------------------------
// indexed_insert_remove_list
// Fixed-capacity ordered list built as a row of shifting cells.
// ---------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_        in         tuser: kind; tdata: position, item_value
//  m_        out        tdata: read_value, element_count; tuser: status
//
// All cells shift in parallel on the accepting edge, and the result word is
// registered, so one word a cycle is sustained while m_tready stays high.
// The input is ready whenever the result register is empty or being drained.
// Reset clears the element count and the result valid; the cells hold
// undefined data until written.
module indexed_insert_remove_list
    import iirl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // position, item_value, zero fill
    input  logic [KIND_W-1:0]    s_tuser,  // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // read_value, element_count, zero fill
    output logic [STAT_W-1:0]    m_tuser   // status
);

    kind_t                 kind;
    logic [POS_W-1:0]      position;
    logic [VAL_W-1:0]      item_value;
    logic                  accept;

    logic [LIST_CNT_W-1:0] count_reg;
    logic [LIST_CNT_W-1:0] count_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [VAL_W-1:0]      rd_reg;
    logic [VAL_W-1:0]      rd_next;
    logic [CNT_W-1:0]      cnt_out_reg;
    logic [CNT_W-1:0]      cnt_out_next;
    status_t               status_reg;
    status_t               status_next;

    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      count_ext;
    logic                  is_full;
    cell_cmd_t             cmd;

    logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]   pos_hit;
    logic [ELEM_WIDTH-1:0] read_mux;

    assign kind       = kind_t'(s_tuser);
    assign position   = s_tdata[POS_W-1:0];
    assign item_value = s_tdata[POS_W+VAL_W-1:POS_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_ext   = CMP_W'(position);
    assign count_ext = CMP_W'(count_reg);
    assign is_full   = (count_ext == CMP_W'(CAPACITY));

    always_comb begin
        read_mux = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos_hit[i]) begin
                read_mux = read_mux | cell_data[i];
            end
        end
    end

    always_comb begin
        count_next  = count_reg;
        status_next = ST_OK;
        rd_next     = '0;
        cmd.ins_en  = 1'b0;
        cmd.rem_en  = 1'b0;
        cmd.pos     = pos_ext;
        cmd.count   = count_ext;
        cmd.value   = ELEM_WIDTH'(item_value);
        unique case (kind)
            KIND_INSERT: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else if (pos_ext > count_ext) begin
                    status_next = ST_RANGE;
                end else begin
                    cmd.ins_en = accept;
                    count_next = LIST_CNT_W'(count_reg + LIST_CNT_W'(1));
                end
            end
            KIND_REMOVE: begin
                if (pos_ext >= count_ext) begin
                    status_next = ST_RANGE;
                end else begin
                    cmd.rem_en = accept;
                    count_next = LIST_CNT_W'(count_reg - LIST_CNT_W'(1));
                end
            end
            KIND_READ: begin
                if (pos_ext >= count_ext) begin
                    status_next = ST_RANGE;
                end else begin
                    rd_next = VAL_W'(read_mux);
                end
            end
            KIND_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        cnt_out_next = CNT_W'(count_next);
    end

    assign m_valid_next = accept ? 1'b1 : (m_valid_reg && !m_tready);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ELEM_WIDTH-1:0] left_d;
            logic [ELEM_WIDTH-1:0] right_d;
            if (g == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_left
                assign left_d = cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_right
                assign right_d = cell_data[g+1];
            end
            iirl_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .cell_index (CMP_W'(g)),
                .left_data  (left_d),
                .right_data (right_d),
                .cell_data  (cell_data[g]),
                .pos_hit    (pos_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg      <= rd_next;
            cnt_out_reg <= cnt_out_next;
            status_reg  <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({cnt_out_reg, rd_reg});
    assign m_tuser  = status_reg;

endmodule
